@@ rtl/core/rlsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rlsc_pkg
// Shared types and constants for the run-length stack with capacity.
// ----------------------------------------------------------------------------
package rlsc_pkg;

  // Run store geometry
  localparam int RUN_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(RUN_DEPTH);
  localparam int PTR_W     = $clog2(RUN_DEPTH + 1);

  // Field widths
  localparam int CNT_W = 31;
  localparam int VAL_W = 32;
  localparam int RUN_W = VAL_W + CNT_W;

  // Operation codes
  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_TOP  = 2'd2,
    MODE_SIZE = 2'd3
  } mode_t;

  // Status codes reported with every result
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_code_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_TOP,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;      // latch input fields, clear top value
    logic push_commit;  // write new run, bump pointer and total
    logic set_full;     // latch FULL error
    logic set_empty;    // latch EMPTY error
    logic pop_start;    // reduce total, load remainder, read top run
    logic pop_step;     // drop or trim the run just read
    logic top_load;     // capture value of the top run
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic  err;         // an error is latched
    mode_t mode;        // captured operation
    logic  push_over;   // total + count exceeds capacity
    logic  n_zero;      // count is zero
    logic  ptr_full;    // run store holds its maximum
    logic  pop_over;    // count exceeds total
    logic  top_empty;   // nothing to report on top
    logic  pop_drop;    // run read is consumed whole
    logic  pop_last;    // this drop finishes the pop
  } dp_stat_t;

endpackage

@@ rtl/core/rlsc_ram.sv @@
// ----------------------------------------------------------------------------
// rlsc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rlsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/rlsc_dpath.sv @@
// ----------------------------------------------------------------------------
// rlsc_dpath
// Datapath: capacity, run pointer, item total, error latch, run store.
// ----------------------------------------------------------------------------
module rlsc_dpath (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [30:0]             cfg_wr_data,
  input  logic [1:0]              mode,
  input  logic [30:0]             count,
  input  logic signed [31:0]      push_value,
  input  rlsc_pkg::dp_cmd_t       cmd,
  output rlsc_pkg::dp_stat_t      stat,
  output logic [1:0]              status,
  output logic signed [31:0]      top_value,
  output logic [30:0]             total_size
);

  logic [rlsc_pkg::CNT_W-1:0]  capacity;
  logic [rlsc_pkg::PTR_W-1:0]  run_pointer;
  logic [rlsc_pkg::CNT_W-1:0]  item_total;
  rlsc_pkg::stat_code_t        error_latch;
  rlsc_pkg::mode_t             op_mode;
  logic [rlsc_pkg::CNT_W-1:0]  op_count;
  logic [rlsc_pkg::VAL_W-1:0]  op_value;
  logic [rlsc_pkg::CNT_W-1:0]  remain;
  logic [rlsc_pkg::VAL_W-1:0]  top_reg;

  logic [rlsc_pkg::CNT_W:0]    push_sum;
  logic [rlsc_pkg::PTR_W-1:0]  ptr_m1;
  logic [rlsc_pkg::PTR_W-1:0]  ptr_m2;
  logic                        ram_wr_en;
  logic [rlsc_pkg::ADDR_W-1:0] ram_wr_addr;
  logic [rlsc_pkg::RUN_W-1:0]  ram_wr_data;
  logic [rlsc_pkg::ADDR_W-1:0] ram_rd_addr;
  logic [rlsc_pkg::RUN_W-1:0]  ram_rd_data;
  logic [rlsc_pkg::VAL_W-1:0]  rd_val;
  logic [rlsc_pkg::CNT_W-1:0]  rd_cnt;

  // Arithmetic on held state
  assign push_sum = {1'b0, item_total} + {1'b0, op_count};
  assign ptr_m1   = run_pointer - rlsc_pkg::PTR_W'(1);
  assign ptr_m2   = run_pointer - rlsc_pkg::PTR_W'(2);
  assign rd_val   = ram_rd_data[rlsc_pkg::RUN_W-1:rlsc_pkg::CNT_W];
  assign rd_cnt   = ram_rd_data[rlsc_pkg::CNT_W-1:0];

  // Status to controller
  always_comb begin
    stat.err       = (error_latch != rlsc_pkg::STAT_OK);
    stat.mode      = op_mode;
    stat.push_over = (push_sum > {1'b0, capacity});
    stat.n_zero    = (op_count == '0);
    stat.ptr_full  = (run_pointer == rlsc_pkg::PTR_W'(rlsc_pkg::RUN_DEPTH));
    stat.pop_over  = (op_count > item_total);
    stat.top_empty = (item_total == '0) || (run_pointer == '0);
    stat.pop_drop  = (rd_cnt <= remain);
    stat.pop_last  = (rd_cnt == remain) || (run_pointer == rlsc_pkg::PTR_W'(1));
  end

  // Run store port control
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = ptr_m1[rlsc_pkg::ADDR_W-1:0];
    ram_wr_data = {rd_val, rd_cnt - remain};
    if (cmd.push_commit) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = run_pointer[rlsc_pkg::ADDR_W-1:0];
      ram_wr_data = {op_value, op_count};
    end else if (cmd.pop_step && !stat.pop_drop) begin
      ram_wr_en   = 1'b1;
    end
    // a drop that continues reads the run below
    if (cmd.pop_step && stat.pop_drop) begin
      ram_rd_addr = ptr_m2[rlsc_pkg::ADDR_W-1:0];
    end else begin
      ram_rd_addr = ptr_m1[rlsc_pkg::ADDR_W-1:0];
    end
  end

  rlsc_ram #(
    .WIDTH (rlsc_pkg::RUN_W),
    .DEPTH (rlsc_pkg::RUN_DEPTH)
  ) u_runs (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Stack control state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_pointer <= '0;
      item_total  <= '0;
      error_latch <= rlsc_pkg::STAT_OK;
    end else begin
      if (cmd.set_full) begin
        error_latch <= rlsc_pkg::STAT_FULL;
      end
      if (cmd.set_empty) begin
        error_latch <= rlsc_pkg::STAT_EMPTY;
      end
      if (cmd.push_commit) begin
        run_pointer <= run_pointer + rlsc_pkg::PTR_W'(1);
        item_total  <= push_sum[rlsc_pkg::CNT_W-1:0];
      end
      if (cmd.pop_start) begin
        item_total <= item_total - op_count;
      end
      if (cmd.pop_step && stat.pop_drop) begin
        run_pointer <= ptr_m1;
      end
    end
  end

  // Operand capture, pop remainder and top value
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_mode  <= rlsc_pkg::mode_t'(mode);
      op_count <= count;
      op_value <= push_value;
      top_reg  <= '0;
    end
    if (cmd.pop_start) begin
      remain <= op_count;
    end
    if (cmd.pop_step) begin
      remain <= stat.pop_drop ? remain - rd_cnt : '0;
    end
    if (cmd.top_load) begin
      top_reg <= rd_val;
    end
  end

  assign status     = error_latch;
  assign top_value  = top_reg;
  assign total_size = item_total;

endmodule

@@ rtl/core/rlsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rlsc_ctrl
// Controller: sequences one transaction through decide, run walk and report.
// ----------------------------------------------------------------------------
module rlsc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  rlsc_pkg::dp_stat_t stat,
  output rlsc_pkg::dp_cmd_t  cmd
);

  rlsc_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rlsc_pkg::ST_IDLE: begin
        if (start) state_next = rlsc_pkg::ST_EXEC;
      end
      rlsc_pkg::ST_EXEC: begin
        state_next = rlsc_pkg::ST_DONE;
        if (!stat.err) begin
          if (stat.mode == rlsc_pkg::MODE_POP && !stat.pop_over && !stat.n_zero) begin
            state_next = rlsc_pkg::ST_POP;
          end else if (stat.mode == rlsc_pkg::MODE_TOP && !stat.top_empty) begin
            state_next = rlsc_pkg::ST_TOP;
          end
        end
      end
      rlsc_pkg::ST_POP: begin
        if (!stat.pop_drop || stat.pop_last) state_next = rlsc_pkg::ST_DONE;
      end
      rlsc_pkg::ST_TOP:  state_next = rlsc_pkg::ST_DONE;
      rlsc_pkg::ST_DONE: state_next = rlsc_pkg::ST_IDLE;
      default:           state_next = rlsc_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd  = '0;
    busy = (state != rlsc_pkg::ST_IDLE);
    done = 1'b0;
    unique case (state)
      rlsc_pkg::ST_IDLE: begin
        cmd.capture = start;
      end
      rlsc_pkg::ST_EXEC: begin
        if (!stat.err) begin
          unique case (stat.mode)
            rlsc_pkg::MODE_PUSH: begin
              if (stat.push_over) begin
                cmd.set_full = 1'b1;
              end else if (!stat.n_zero) begin
                if (stat.ptr_full) cmd.set_full = 1'b1;
                else               cmd.push_commit = 1'b1;
              end
            end
            rlsc_pkg::MODE_POP: begin
              if (stat.pop_over)     cmd.set_empty = 1'b1;
              else if (!stat.n_zero) cmd.pop_start = 1'b1;
            end
            rlsc_pkg::MODE_TOP: begin
              cmd.set_empty = stat.top_empty;
            end
            rlsc_pkg::MODE_SIZE: begin
            end
            default: begin
            end
          endcase
        end
      end
      rlsc_pkg::ST_POP:  cmd.pop_step = 1'b1;
      rlsc_pkg::ST_TOP:  cmd.top_load = 1'b1;
      rlsc_pkg::ST_DONE: done = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/run_length_stack_with_capacity.sv @@
// ----------------------------------------------------------------------------
// run_length_stack_with_capacity
// Stack held as runs of a repeated value, bounded by a configured capacity.
// ----------------------------------------------------------------------------
// Sequence from accept to done: decide, then report; top first reads the top
// run, and pop first takes one step per run dropped or trimmed (one run-store
// read each). A new transaction is accepted only once idle again after done.
// Results show for one cycle on done; the receiver cannot stall.
// Reset clears capacity, run pointer, total and error latch; the run store
// is not cleared.
module run_length_stack_with_capacity (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [30:0]        count,
  input  logic signed [31:0] push_value,
  input  logic               cfg_wr_en,
  input  logic [30:0]        cfg_wr_data,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] top_value,
  output logic [30:0]        total_size
);

  rlsc_pkg::dp_cmd_t  cmd;
  rlsc_pkg::dp_stat_t stat;

  rlsc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  rlsc_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mode        (mode),
    .count       (count),
    .push_value  (push_value),
    .cmd         (cmd),
    .stat        (stat),
    .status      (status),
    .top_value   (top_value),
    .total_size  (total_size)
  );

endmodule

@@ verif/tb_run_length_stack_with_capacity.sv @@
// ----------------------------------------------------------------------------
// tb_run_length_stack_with_capacity
// Self-checking bench for the run-length stack. It runs directed and random
// push, pop, top and size commands under several capacity settings and checks
// every result against a behavioral run-store model in issue order. It ends by
// latching one error kind and checking that later commands are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_run_length_stack_with_capacity;
  import rlsc_pkg::*;

  localparam int          CYCLE_LIMIT = 600000;
  localparam logic [30:0] CAP_MAX     = 31'h7FFF_FFFF;

  // Error paths for the closing test
  typedef enum int {
    ERR_PUSH_OVER,
    ERR_STORE_FULL,
    ERR_POP_OVER,
    ERR_TOP_EMPTY,
    ERR_ZERO_PUSH_OVER
  } err_path_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] top;
    logic [30:0]        size;
  } stack_result_t;

  // DUT ports
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  mode_t              mode = MODE_SIZE;
  logic [30:0]        count = '0;
  logic signed [31:0] push_value = '0;
  logic               cfg_wr_en = 1'b0;
  logic [30:0]        cfg_wr_data = '0;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] top_value;
  logic [30:0]        total_size;

  // Shadow stack state
  logic signed [31:0] run_vals [RUN_DEPTH];
  logic [30:0]        run_cnts [RUN_DEPTH];
  int                 runs_held = 0;
  logic [30:0]        total = '0;
  stat_code_t         err_state = STAT_OK;
  logic [30:0]        capacity = '0;

  stack_result_t pending_results[$];
  stack_result_t want;
  int            mismatch_count = 0;
  int            stray_count = 0;
  int            checked_count = 0;
  int            op_seen [4] = '{0, 0, 0, 0};
  int            burst_left = 0;
  int            cycle_count = 0;
  err_path_t     err_path;

  run_length_stack_with_capacity dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .count       (count),
    .push_value  (push_value),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .done        (done),
    .status      (status),
    .top_value   (top_value),
    .total_size  (total_size)
  );

  always #5 clk = ~clk;

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Result checker: one result per done strobe, compared in order
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        stray_count++;
        $display("unexpected result: status %0d top %0d size %0d", status, top_value,
                 total_size);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (status !== want.status || top_value !== want.top || total_size !== want.size)
        begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch on result %0d: want status %0d top %0d size %0d, got %0d %0d %0d",
                     checked_count, want.status, want.top, want.size,
                     status, top_value, total_size);
        end
      end
    end
  end

  // Shadow model: apply one accepted transaction and queue its result
  task automatic predict_op(mode_t m, logic [30:0] n, logic signed [31:0] v);
    stack_result_t res;
    logic [31:0]   sum;
    logic [30:0]   rem;
    res.top = '0;
    op_seen[m]++;
    if (err_state == STAT_OK) begin
      case (m)
        MODE_PUSH: begin
          sum = {1'b0, total} + {1'b0, n};
          if (sum > {1'b0, capacity}) begin
            err_state = STAT_FULL;
          end else if (n != 0) begin
            if (runs_held >= RUN_DEPTH) begin
              err_state = STAT_FULL;
            end else begin
              run_vals[runs_held] = v;
              run_cnts[runs_held] = n;
              runs_held++;
              total = sum[30:0];
            end
          end
        end
        MODE_POP: begin
          if (n > total) begin
            err_state = STAT_EMPTY;
          end else begin
            total = total - n;
            rem = n;
            // drop whole runs, trim the last one touched
            while (rem != 0 && runs_held > 0) begin
              if (run_cnts[runs_held-1] <= rem) begin
                rem = rem - run_cnts[runs_held-1];
                runs_held--;
              end else begin
                run_cnts[runs_held-1] = run_cnts[runs_held-1] - rem;
                rem = '0;
              end
            end
          end
        end
        MODE_TOP: begin
          if (total == 0 || runs_held == 0) err_state = STAT_EMPTY;
          else res.top = run_vals[runs_held-1];
        end
        default: ;
      endcase
    end
    res.status = err_state;
    res.size   = total;
    pending_results.push_back(res);
  endtask

  // Send one command; the sender issues in bursts with random idle gaps between them
  task automatic issue_op(mode_t m, logic [30:0] n, logic signed [31:0] v);
    int gap;
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    start      <= 1'b1;
    mode       <= m;
    count      <= n;
    push_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    predict_op(m, n, v);
    start <= 1'b0;
  endtask

  // Capacity write, only once all results are back
  task automatic write_capacity(logic [30:0] value);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity = value;
  endtask

  function automatic logic [30:0] pick_count(logic [30:0] lim);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (lim == 0) return '0;
    case (sel)
      0:       return '0;
      1:       return lim;
      2, 3, 4: return 31'($urandom_range({1'b0, lim}, 0));
      default: return 31'($urandom_range((lim < 8) ? 8'(lim) : 8, 1));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Pop sizes: exact run boundaries, boundary plus a trim, or anything legal
  function automatic logic [30:0] pick_pop();
    int          sel;
    int          k;
    int          i;
    logic [31:0] acc;
    sel = $urandom_range(0, 3);
    if (sel == 0 || runs_held == 0) return pick_count(total);
    k = $urandom_range(1, (runs_held < 6) ? runs_held : 6);
    acc = '0;
    for (i = 0; i < k; i++) acc += run_cnts[runs_held-1-i];
    if (sel == 1 && k < runs_held && run_cnts[runs_held-1-k] > 1)
      acc += $urandom_range({1'b0, run_cnts[runs_held-1-k]} - 1, 1);
    return acc[30:0];
  endfunction

  // Legal random traffic: nothing here may latch an error
  task automatic run_random(int n_items);
    int unsigned sel;
    logic [30:0] room;
    repeat (n_items) begin
      sel  = $urandom_range(0, 99);
      room = (runs_held >= RUN_DEPTH) ? 31'd0 : capacity - total;
      if (sel < 42)
        issue_op(MODE_PUSH, pick_count(room), pick_value());
      else if (sel < 72)
        issue_op(MODE_POP, pick_pop(), pick_value());
      else if (sel < 86 && total != 0)
        issue_op(MODE_TOP, 31'($urandom), pick_value());
      else
        issue_op(MODE_SIZE, 31'($urandom), pick_value());
    end
  endtask

  // Empty stack after reset with capacity still zero
  task automatic test_reset_state();
    issue_op(MODE_SIZE, '0, '0);
    issue_op(MODE_PUSH, '0, 32'sh7FFF_FFFF);
    issue_op(MODE_POP, '0, '0);
  endtask

  // Value and count extremes, trims and multi-run pops at full capacity
  task automatic test_push_extremes();
    write_capacity(CAP_MAX);
    issue_op(MODE_PUSH, 31'd1, 32'sh7FFF_FFFF);
    issue_op(MODE_PUSH, 31'd1, 32'sh8000_0000);
    issue_op(MODE_TOP, '0, '0);
    issue_op(MODE_PUSH, 31'd3, -32'sd1);
    issue_op(MODE_TOP, '0, '0);
    issue_op(MODE_SIZE, '0, '0);
    issue_op(MODE_POP, '0, '0);
    issue_op(MODE_POP, 31'd2, '0);
    issue_op(MODE_TOP, '0, '0);
    issue_op(MODE_POP, 31'd2, '0);
    issue_op(MODE_TOP, '0, '0);
    issue_op(MODE_PUSH, CAP_MAX - total, '0);
    issue_op(MODE_SIZE, CAP_MAX, -32'sd1);
    issue_op(MODE_TOP, '0, '0);
    issue_op(MODE_POP, CAP_MAX, '0);
    issue_op(MODE_SIZE, '0, '0);
  endtask

  // Capacity dropped below the held total: items stay, pops still work
  task automatic test_capacity_lowered();
    issue_op(MODE_PUSH, 31'd10, 32'sd5);
    issue_op(MODE_PUSH, 31'd10, 32'sd6);
    write_capacity('0);
    issue_op(MODE_TOP, '0, '0);
    issue_op(MODE_SIZE, '0, '0);
    issue_op(MODE_POP, 31'd3, '0);
    issue_op(MODE_POP, total, '0);
  endtask

  // Small capacity; the stack is emptied first so the total fits under it
  task automatic test_random_narrow(int n_items);
    if (total != 0) issue_op(MODE_POP, total, '0);
    write_capacity(31'($urandom_range(30, 400)));
    run_random(n_items);
  endtask

  task automatic test_random_wide(int n_items);
    write_capacity(CAP_MAX);
    run_random(n_items);
  endtask

  // Latch one error kind, then check that everything after it is ignored
  task automatic test_error_latch();
    if (total != 0) issue_op(MODE_POP, total, '0);
    case (err_path)
      ERR_PUSH_OVER: begin
        write_capacity(31'($urandom_range(0, 100)));
        issue_op(MODE_PUSH, capacity + 31'd1, pick_value());
      end
      ERR_STORE_FULL: begin
        write_capacity(CAP_MAX);
        while (runs_held < RUN_DEPTH)
          issue_op(MODE_PUSH, 31'($urandom_range(1, 3)), pick_value());
        issue_op(MODE_TOP, '0, '0);
        issue_op(MODE_PUSH, 31'd1, pick_value());
      end
      ERR_POP_OVER: begin
        issue_op(MODE_PUSH, 31'd7, pick_value());
        issue_op(MODE_POP, total + 31'($urandom_range(1, 9)), '0);
      end
      ERR_TOP_EMPTY: begin
        issue_op(MODE_TOP, '0, '0);
      end
      default: begin
        issue_op(MODE_PUSH, 31'd5, pick_value());
        write_capacity(31'd4);
        issue_op(MODE_PUSH, '0, pick_value());
      end
    endcase
    repeat (40)
      issue_op(mode_t'($urandom_range(0, 3)), 31'($urandom), $urandom);
  endtask

  initial begin
    err_path = err_path_t'($urandom_range(0, 4));
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_push_extremes();
    test_capacity_lowered();
    // filling the run store takes about a thousand pushes, so random traffic
    // is cut back on that path
    if (err_path == ERR_STORE_FULL) begin
      test_random_narrow(80);
      test_random_wide(80);
      test_random_narrow(80);
    end else begin
      test_random_narrow(480);
      test_random_wide(400);
      test_random_narrow(450);
    end
    test_error_latch();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d results checked (%0d push, %0d pop, %0d top, %0d size)",
             checked_count, op_seen[MODE_PUSH], op_seen[MODE_POP], op_seen[MODE_TOP],
             op_seen[MODE_SIZE]);
    $display("capacity settings from zero to full range; closing error path %s",
             err_path.name());
    if (mismatch_count == 0 && stray_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d unexpected results", mismatch_count, stray_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
